// ===== src/bilinear_grid_interpolator_unit_macros.svh =====
// Assertion macros used by the bilinear grid interpolator back end.
`ifndef BILINEAR_GRID_INTERPOLATOR_UNIT_MACROS_SVH
`define BILINEAR_GRID_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define BGI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define BGI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bgi_pkg.sv =====
// Types and constants of the bilinear grid interpolator.
package bgi_pkg;

	localparam int VAL_W     = 32;
	localparam int CFG_W     = 7;
	localparam int CNT_W     = 11;
	localparam int IDX_W     = 6;
	localparam int TYPE_W    = 2;
	localparam int DVD_W     = 49;
	localparam int DVS_W     = 33;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CYCLES = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_PAD_W = DIV_CYCLES * DIV_STEPS;
	localparam int CHUNK_W   = 11;
	localparam int CHUNKS    = DVS_W / CHUNK_W;
	localparam int ACC_W     = DVD_W + DVS_W;
	localparam int PP_W      = DVD_W + CHUNK_W;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [ACC_W-1:0] PROD_LIM = ACC_W'(1) << 62;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD_X    = 2'd0,
		REQ_LOAD_Y    = 2'd1,
		REQ_LOAD_GRID = 2'd2,
		REQ_QUERY     = 2'd3
	} req_kind_t;

	typedef enum logic [0:0] {
		CFG_X_POINTS = 1'b0,
		CFG_Y_POINTS = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		STEP_X_LO = 2'd0,
		STEP_X_HI = 2'd1,
		STEP_Y    = 2'd2
	} lin_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XS_RD,
		ST_XS_CMP,
		ST_YS_RD,
		ST_YS_CMP,
		ST_FETCH,
		ST_FETCH_WAIT,
		ST_LSETUP,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		req_kind_t                 kind;
		logic                      idx_ok;
		logic [IDX_W-1:0]          col;
		logic [IDX_W-1:0]          row;
		logic signed [VAL_W-1:0]   value;
		logic signed [VAL_W-1:0]   qx;
		logic signed [VAL_W-1:0]   qy;
	} bgi_item_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/bgi_req_if.sv =====
// Input channel of the bilinear grid interpolator: loads and queries.
interface bgi_req_if import bgi_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [TYPE_W-1:0]       req_type;
	logic [IDX_W-1:0]        load_col;
	logic [IDX_W-1:0]        load_row;
	logic signed [VAL_W-1:0] load_value;
	logic signed [VAL_W-1:0] query_x;
	logic signed [VAL_W-1:0] query_y;

	modport source (output valid, req_type, load_col, load_row, load_value, query_x, query_y,
		input ready);
	modport sink (input valid, req_type, load_col, load_row, load_value, query_x, query_y,
		output ready);
endinterface

// ===== src/bgi_rsp_if.sv =====
// Result channel of the bilinear grid interpolator.
interface bgi_rsp_if import bgi_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] interp_value;
	logic                    status;

	modport source (output valid, interp_value, status, input ready);
	modport sink (input valid, interp_value, status, output ready);
endinterface

// ===== src/bgi_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module bgi_front import bgi_pkg::*; #(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bgi_req_if.sink   req,
	output bgi_item_t item,
	output logic      item_valid,
	input  logic      item_take
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	bgi_item_t        queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	bgi_item_t        cls;
	logic             push, pop;
	logic             col_ok, row_ok;

	assign req.ready = (count_q < (PTR_W+1)'(QUEUE_DEPTH));
	assign push = req.valid && req.ready;
	assign pop  = item_take && item_valid;

	assign col_ok = (CNT_W'(req.load_col) < CNT_W'(MAX_X_POINTS));
	assign row_ok = (CNT_W'(req.load_row) < CNT_W'(MAX_Y_POINTS));

	always_comb begin
		cls.kind  = req_kind_t'(req.req_type);
		cls.col   = req.load_col;
		cls.row   = req.load_row;
		cls.value = req.load_value;
		cls.qx    = req.query_x;
		cls.qy    = req.query_y;
		case (cls.kind)
			REQ_LOAD_X:    cls.idx_ok = col_ok;
			REQ_LOAD_Y:    cls.idx_ok = row_ok;
			REQ_LOAD_GRID: cls.idx_ok = col_ok && row_ok;
			default:       cls.idx_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(({1'b0, wr_ptr_q} + 1'b1) % QUEUE_DEPTH);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(({1'b0, rd_ptr_q} + 1'b1) % QUEUE_DEPTH);
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	assign item       = queue_q[rd_ptr_q];
	assign item_valid = (count_q != '0);

endmodule

// ===== src/bgi_div.sv =====
// Shared unsigned divider: restoring, DIV_STEPS quotient bits per cycle while busy.
module bgi_div import bgi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t div_req,
	output div_rsp_t div_rsp
);
	localparam int CNT_DW = $clog2(DIV_CYCLES + 1);

	logic                  busy_q, done_q;
	logic [CNT_DW-1:0]     cnt_q;
	logic [DVS_W:0]        rem_q;
	logic [DIV_PAD_W-1:0]  dvd_q, quo_q;
	logic [DVS_W-1:0]      dvs_q;
	logic [DVS_W:0]        rem_c;
	logic [DIV_PAD_W-1:0]  dvd_c, quo_c;

	always_comb begin
		rem_c = rem_q;
		dvd_c = dvd_q;
		quo_c = quo_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_c = {rem_c[DVS_W-1:0], dvd_c[DIV_PAD_W-1]};
			dvd_c = {dvd_c[DIV_PAD_W-2:0], 1'b0};
			if (rem_c >= {1'b0, dvs_q}) begin
				rem_c = rem_c - {1'b0, dvs_q};
				quo_c = {quo_c[DIV_PAD_W-2:0], 1'b1};
			end else begin
				quo_c = {quo_c[DIV_PAD_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			rem_q <= '0;
			dvd_q <= DIV_PAD_W'(div_req.dividend);
			quo_q <= '0;
			dvs_q <= div_req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_c;
			dvd_q <= dvd_c;
			quo_q <= quo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (div_req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_DW'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign div_rsp.done     = done_q;
	assign div_rsp.quotient = quo_q[DVD_W-1:0];

endmodule

// ===== src/bgi_back.sv =====
// Back end: axis and grid memories, index search and the interpolation sequencer.
`include "bilinear_grid_interpolator_unit_macros.svh"
module bgi_back import bgi_pkg::*; #(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] x_points,
	input  logic [CFG_W-1:0] y_points,
	input  bgi_item_t        item,
	input  logic             item_valid,
	output logic             item_take,
	output div_req_t         div_req,
	input  div_rsp_t         div_rsp,
	bgi_rsp_if.source        rsp
);
	localparam int XW = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
	localparam int YW = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
	localparam int GW = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
	localparam int SW = (XW > YW) ? XW : YW;

	back_state_t state_q, state_d;

	logic signed [VAL_W-1:0] x_mem [MAX_X_POINTS];
	logic signed [VAL_W-1:0] y_mem [MAX_Y_POINTS];
	logic signed [VAL_W-1:0] g_mem [MAX_X_POINTS * MAX_Y_POINTS];
	logic signed [VAL_W-1:0] x_rdata_q, y_rdata_q, g_rdata_q;
	logic x_we, y_we, g_we;
	logic [XW-1:0] x_waddr, x_raddr;
	logic [YW-1:0] y_waddr, y_raddr;
	logic [GW-1:0] g_waddr, g_raddr;

	logic [CNT_W-1:0] nx_eff, ny_eff;
	logic signed [VAL_W-1:0] qx_q, qy_q;
	logic [SW-1:0] lo_q, hi_q, mid_q, ny_m1_q, mid_c;
	logic          span_gt1;
	logic          x_multi_q, y_multi_q;
	logic [XW-1:0] xl_q, xh;
	logic [YW-1:0] yl_q, yh;
	logic [1:0]    fk_q, rd_k_s1;
	logic          rd_v_s1;
	logic signed [VAL_W-1:0] g_q [4];
	logic signed [VAL_W-1:0] px_lo_q, px_hi_q, py_lo_q, py_hi_q;
	logic signed [VAL_W-1:0] f1_q, f2_q, fi_q;
	lin_step_t step_q, step_next;
	logic zero_q, neg_q;

	logic signed [VAL_W-1:0] fl_c, fh_c, pl_c, ph_c, p_c;
	logic signed [VAL_W:0]   diff_c, dp_c, d_c;
	logic signed [DVD_W-1:0] num_c;
	logic [DVD_W-1:0] m_mag_q;
	logic [DVS_W-1:0] d_mag_q;
	logic [ACC_W-1:0] acc_q;
	logic [1:0]       chunk_q;
	logic [PP_W-1:0]  pp_c;
	logic [62:0]      mag_sat_c;
	logic signed [63:0] q_c;
	logic signed [48:0] sum_c;
	logic signed [VAL_W-1:0] res_c;
	logic out_free;
	logic ov_q, ost_q;
	logic signed [VAL_W-1:0] oval_q;

	// effective point counts: zero counts as one, above the store counts as its size
	always_comb begin
		if (x_points == '0) nx_eff = CNT_W'(1);
		else if (CNT_W'(x_points) > CNT_W'(MAX_X_POINTS)) nx_eff = CNT_W'(MAX_X_POINTS);
		else nx_eff = CNT_W'(x_points);
		if (y_points == '0) ny_eff = CNT_W'(1);
		else if (CNT_W'(y_points) > CNT_W'(MAX_Y_POINTS)) ny_eff = CNT_W'(MAX_Y_POINTS);
		else ny_eff = CNT_W'(y_points);
	end

	assign span_gt1 = (({1'b0, hi_q} - {1'b0, lo_q}) > (SW+1)'(1));
	assign mid_c    = SW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign xh = x_multi_q ? XW'({1'b0, xl_q} + 1'b1) : xl_q;
	assign yh = y_multi_q ? YW'({1'b0, yl_q} + 1'b1) : yl_q;

	// operands of the current linear step
	always_comb begin
		case (step_q)
			STEP_X_LO: begin
				fl_c = g_q[0]; fh_c = g_q[1];
				pl_c = px_lo_q; ph_c = px_hi_q; p_c = qx_q;
			end
			STEP_X_HI: begin
				fl_c = g_q[2]; fh_c = g_q[3];
				pl_c = px_lo_q; ph_c = px_hi_q; p_c = qx_q;
			end
			default: begin
				fl_c = x_multi_q ? f1_q : g_q[0];
				fh_c = x_multi_q ? f2_q : g_q[2];
				pl_c = py_lo_q; ph_c = py_hi_q; p_c = qy_q;
			end
		endcase
		case (step_q)
			STEP_X_LO: step_next = STEP_X_HI;
			default:   step_next = STEP_Y;
		endcase
	end

	assign diff_c = {fh_c[VAL_W-1], fh_c} - {fl_c[VAL_W-1], fl_c};
	assign dp_c   = {ph_c[VAL_W-1], ph_c} - {pl_c[VAL_W-1], pl_c};
	assign d_c    = {p_c[VAL_W-1], p_c} - {pl_c[VAL_W-1], pl_c};
	assign num_c  = {diff_c, 16'b0};

	assign pp_c = PP_W'(m_mag_q) * PP_W'(d_mag_q[chunk_q*CHUNK_W +: CHUNK_W]);

	// saturate product magnitude, apply sign, floor by 2^16, add the low end value, clamp to 32 bits
	always_comb begin
		mag_sat_c = (acc_q > PROD_LIM) ? PROD_LIM[62:0] : acc_q[62:0];
		q_c = neg_q ? -$signed({1'b0, mag_sat_c}) : $signed({1'b0, mag_sat_c});
		sum_c = 49'(q_c >>> 16) + 49'(fl_c);
		if (sum_c > 49'(VAL_MAX)) res_c = VAL_MAX;
		else if (sum_c < 49'(VAL_MIN)) res_c = VAL_MIN;
		else res_c = sum_c[VAL_W-1:0];
	end

	assign out_free = !ov_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		item_take = 1'b0;
		x_we = 1'b0; y_we = 1'b0; g_we = 1'b0;
		x_raddr = '0; y_raddr = '0; g_raddr = '0;
		div_req.start    = 1'b0;
		div_req.dividend = num_c[DVD_W-1] ? DVD_W'(-num_c) : DVD_W'(num_c);
		div_req.divisor  = dp_c[VAL_W] ? DVS_W'(-dp_c) : DVS_W'(dp_c);
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_take = 1'b1;
					case (item.kind)
						REQ_LOAD_X:    x_we = item.idx_ok;
						REQ_LOAD_Y:    y_we = item.idx_ok;
						REQ_LOAD_GRID: g_we = item.idx_ok;
						default:       state_d = ST_XS_RD;
					endcase
				end
			end
			ST_XS_RD: begin
				if (span_gt1) begin
					x_raddr = XW'(mid_c);
					state_d = ST_XS_CMP;
				end else begin
					state_d = ST_YS_RD;
				end
			end
			ST_XS_CMP: state_d = ST_XS_RD;
			ST_YS_RD: begin
				if (span_gt1) begin
					y_raddr = YW'(mid_c);
					state_d = ST_YS_CMP;
				end else begin
					state_d = ST_FETCH;
				end
			end
			ST_YS_CMP: state_d = ST_YS_RD;
			ST_FETCH: begin
				x_raddr = fk_q[0] ? xh : xl_q;
				y_raddr = fk_q[0] ? yh : yl_q;
				g_raddr = GW'(GW'(fk_q[0] ? xh : xl_q) * GW'(MAX_Y_POINTS)
					+ GW'(fk_q[1] ? yh : yl_q));
				if (fk_q == 2'd3) state_d = ST_FETCH_WAIT;
			end
			ST_FETCH_WAIT: state_d = ST_LSETUP;
			ST_LSETUP: begin
				if (step_q == STEP_Y && !y_multi_q) begin
					state_d = ST_OUT;
				end else if (dp_c == '0) begin
					state_d = (step_q == STEP_Y) ? ST_OUT : ST_LSETUP;
				end else begin
					div_req.start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: if (div_rsp.done) state_d = ST_MUL;
			ST_MUL: if (chunk_q == 2'(CHUNKS - 1)) state_d = ST_FIN;
			ST_FIN: state_d = (step_q == STEP_Y) ? ST_OUT : ST_LSETUP;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign x_waddr = XW'(item.col);
	assign y_waddr = YW'(item.row);
	assign g_waddr = GW'(GW'(XW'(item.col)) * GW'(MAX_Y_POINTS) + GW'(YW'(item.row)));

	always_ff @(posedge clk) begin
		if (x_we) x_mem[x_waddr] <= item.value;
		x_rdata_q <= x_mem[x_raddr];
	end

	always_ff @(posedge clk) begin
		if (y_we) y_mem[y_waddr] <= item.value;
		y_rdata_q <= y_mem[y_raddr];
	end

	always_ff @(posedge clk) begin
		if (g_we) g_mem[g_waddr] <= item.value;
		g_rdata_q <= g_mem[g_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == ST_FETCH);
			if (state_q == ST_OUT && out_free) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= fk_q;
		if (rd_v_s1) begin
			g_q[rd_k_s1] <= g_rdata_q;
			if (rd_k_s1 == 2'd0) begin
				px_lo_q <= x_rdata_q;
				py_lo_q <= y_rdata_q;
			end
			if (rd_k_s1 == 2'd1) begin
				px_hi_q <= x_rdata_q;
				py_hi_q <= y_rdata_q;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			oval_q <= zero_q ? '0 : fi_q;
			ost_q  <= zero_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (item_valid && item.kind == REQ_QUERY) begin
					qx_q      <= item.qx;
					qy_q      <= item.qy;
					lo_q      <= '0;
					hi_q      <= SW'(nx_eff - 1'b1);
					ny_m1_q   <= SW'(ny_eff - 1'b1);
					x_multi_q <= (nx_eff > CNT_W'(1));
					y_multi_q <= (ny_eff > CNT_W'(1));
					zero_q    <= 1'b0;
				end
			end
			ST_XS_RD: begin
				if (span_gt1) begin
					mid_q <= mid_c;
				end else begin
					xl_q <= XW'(lo_q);
					lo_q <= '0;
					hi_q <= ny_m1_q;
				end
			end
			ST_XS_CMP: begin
				if (x_rdata_q <= qx_q) lo_q <= mid_q;
				else hi_q <= mid_q;
			end
			ST_YS_RD: begin
				if (span_gt1) begin
					mid_q <= mid_c;
				end else begin
					yl_q <= YW'(lo_q);
					fk_q <= '0;
				end
			end
			ST_YS_CMP: begin
				if (y_rdata_q <= qy_q) lo_q <= mid_q;
				else hi_q <= mid_q;
			end
			ST_FETCH: fk_q <= fk_q + 1'b1;
			ST_FETCH_WAIT: step_q <= x_multi_q ? STEP_X_LO : STEP_Y;
			ST_LSETUP: begin
				if (step_q == STEP_Y && !y_multi_q) begin
					fi_q <= fl_c;
				end else if (dp_c == '0) begin
					// zero spacing: flag it and move on, the result is forced to zero
					zero_q <= 1'b1;
					step_q <= step_next;
				end else begin
					// product sign: value step, spacing and offset all count
					neg_q   <= num_c[DVD_W-1] ^ dp_c[VAL_W] ^ d_c[VAL_W];
					d_mag_q <= d_c[VAL_W] ? DVS_W'(-d_c) : DVS_W'(d_c);
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					m_mag_q <= div_rsp.quotient;
					acc_q   <= '0;
					chunk_q <= '0;
				end
			end
			ST_MUL: begin
				acc_q   <= acc_q + (ACC_W'(pp_c) << (CHUNK_W * chunk_q));
				chunk_q <= chunk_q + 1'b1;
			end
			ST_FIN: begin
				case (step_q)
					STEP_X_LO: f1_q <= res_c;
					STEP_X_HI: f2_q <= res_c;
					default:   fi_q <= res_c;
				endcase
				step_q <= step_next;
			end
			default: ;
		endcase
	end

	assign rsp.valid        = ov_q;
	assign rsp.interp_value = oval_q;
	assign rsp.status       = ost_q;

	`BGI_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == ST_DIV, "divider finished outside the divide step")
	`BGI_ASSERT_IMP(a_mid_in_span, state_q == ST_XS_CMP || state_q == ST_YS_CMP, mid_q > lo_q && mid_q < hi_q, "search probe outside the bracket")
	`BGI_ASSERT_NEXT(a_zero_spacing_out, state_q == ST_OUT && out_free && zero_q, rsp.valid && rsp.status && rsp.interp_value == '0, "zero spacing result not zero")

endmodule

// ===== src/bilinear_grid_interpolator_unit.sv =====
// Bilinear interpolator over a loaded rectilinear grid, signed Q16.16 throughout.
// Load items (x coordinate, y coordinate, grid value) are written to their store from the idle
// state; a query runs an index search and a memory fetch, then linear steps (each a wait on
// the shared divider and a chunked slope multiply, unless the spacing is zero), three steps
// when both axes have two or more points, then the result hand-off. A two-item queue in
// front of the engine keeps taking items while a query runs, as long as it has room, and a
// registered result waits for the consumer without stopping the engine from draining loads.
// Axis and grid stores are memories with one write and one read port and no reset; reading
// an entry never loaded gives an arbitrary value.
module bilinear_grid_interpolator_unit import bgi_pkg::*; #(
	parameter int MAX_X_POINTS = 64,
	parameter int MAX_Y_POINTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bgi_req_if.sink          req,
	bgi_rsp_if.source        rsp
);
	logic [CFG_W-1:0] x_points_q, y_points_q;
	bgi_item_t item;
	logic      item_valid, item_take;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_points_q <= CFG_W'(1);
			y_points_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_X_POINTS: x_points_q <= cfg_data;
				CFG_Y_POINTS: y_points_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bgi_front #(
		.MAX_X_POINTS(MAX_X_POINTS),
		.MAX_Y_POINTS(MAX_Y_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	bgi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	bgi_back #(
		.MAX_X_POINTS(MAX_X_POINTS),
		.MAX_Y_POINTS(MAX_Y_POINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.x_points   (x_points_q),
		.y_points   (y_points_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.rsp        (rsp)
	);

endmodule
